FILE: hdl/assert_macros.svh
// Assertion helpers shared by the lyric time tag parser modules.
// No dependencies; included by every module that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is high.
`define CHK_PROP(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define CHK_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/lttp_pkg.sv
// Types and constants for the lyric time tag parser.
// No dependencies; used by lttp_scan, lttp_calc and the top level.
package lttp_pkg;

   typedef enum logic [1:0] {
      PH_WAIT = 2'd0,
      PH_MIN  = 2'd1,
      PH_SEC  = 2'd2,
      PH_FRAC = 2'd3
   } phase_type;

   localparam logic [7:0] CH_OPEN  = 8'h5B;  // [
   localparam logic [7:0] CH_CLOSE = 8'h5D;  // ]
   localparam logic [7:0] CH_COLON = 8'h3A;  // :
   localparam logic [7:0] CH_DOT   = 8'h2E;  // .
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam int TIME_W = 26;
   localparam logic [TIME_W-1:0] MS_PER_MIN = 26'd60000;
   localparam logic [16:0]       MS_PER_SEC = 17'd1000;
   // [999:99:999]
   localparam logic [TIME_W-1:0] TIME_MAX   = 26'd60039999;

   // Parsed tag as it leaves the scanner
   typedef struct packed {
      logic       is_tag;
      logic [9:0] minutes;
      logic [6:0] seconds;
      logic [9:0] frac_ms;
   } tag_type;

endpackage

FILE: hdl/lyric_time_tag_parser.sv
// Lyric time tag parser top level: scanner followed by the millisecond result stage.
// Depends on lttp_pkg, lttp_scan and lttp_calc.
//
//   channel   direction  handshake            word
//   req_      in         req_valid/req_stall  req_text_byte[7:0]
//   rsp_      out        rsp_valid/rsp_stall  rsp_is_time_tag, rsp_time_ms[25:0]
//
// One byte per cycle while req_stall is low; a result passes the scanner register, then the result register.
// The scanner register and the result register each hold one word, so a byte is
// accepted while a finished word waits on rsp_stall; req_stall rises only when both are full.
// Synchronous active-high reset returns the scanner to waiting for '[' and empties both stages.

module lyric_time_tag_parser
   import lttp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_text_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_is_time_tag,
   output logic [TIME_W-1:0] rsp_time_ms
);

   logic    mid_valid;
   logic    mid_ready;
   tag_type mid_tag;

   lttp_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .text_byte (req_text_byte),
      .out_ready (mid_ready),
      .in_stall  (req_stall),
      .mid_valid (mid_valid),
      .mid_tag   (mid_tag)
   );

   lttp_calc u_calc (
      .clock           (clock),
      .reset           (reset),
      .mid_valid       (mid_valid),
      .mid_tag         (mid_tag),
      .mid_ready       (mid_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_is_time_tag (rsp_is_time_tag),
      .rsp_time_ms     (rsp_time_ms)
   );

endmodule

FILE: hdl/lttp_scan.sv
// Byte scanner: tag grammar state machine and the parsed-tag register.
// Depends on lttp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lttp_scan
   import lttp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  logic [7:0] text_byte,
   input  logic       out_ready,
   output logic       in_stall,
   output logic       mid_valid,
   output tag_type    mid_tag
);

   phase_type  phase_ff, phase_in;
   logic [1:0] count_ff, count_in;
   logic [9:0] min_ff, min_in;
   logic [6:0] sec_ff, sec_in;
   logic [9:0] frac_ff, frac_in;
   logic       mid_valid_ff, mid_valid_in;
   tag_type    tag_ff, tag_in;

   logic        take;
   logic        is_digit, is_open, is_close, is_colon, is_sep;
   logic [7:0]  digit_raw;
   logic [3:0]  digit;
   logic [13:0] min_step;
   logic [10:0] sec_step;
   logic [13:0] frac_step;
   logic [16:0] frac_pad;
   logic        hit, miss;

   assign in_stall = mid_valid_ff && !out_ready;
   assign take     = in_valid && !in_stall;

   assign is_digit  = text_byte inside {[CH_ZERO:CH_NINE]};
   assign is_open   = (text_byte == CH_OPEN);
   assign is_close  = (text_byte == CH_CLOSE);
   assign is_colon  = (text_byte == CH_COLON);
   assign is_sep    = text_byte inside {CH_DOT, CH_COLON};
   assign digit_raw = text_byte - CH_ZERO;
   assign digit     = is_digit ? digit_raw[3:0] : 4'd0;

   assign min_step  = 14'(min_ff) * 14'd10 + 14'(digit);
   assign sec_step  = 11'(sec_ff) * 11'd10 + 11'(digit);
   assign frac_step = 14'(frac_ff) * 14'd10 + 14'(digit);

   // Outputs: close / reject decisions and the padded fraction
   always_comb begin
      hit  = 1'b0;
      miss = 1'b0;
      case (phase_ff)
         PH_MIN: begin
            if (is_digit && count_ff != 2'd3) begin
            end else if (is_colon && count_ff != 2'd0) begin
            end else begin
               miss = 1'b1;
            end
         end
         PH_SEC: begin
            if (is_digit && count_ff < 2'd2) begin
            end else if (is_sep && count_ff != 2'd0) begin
            end else if (is_close && count_ff != 2'd0) begin
               hit = 1'b1;
            end else begin
               miss = 1'b1;
            end
         end
         PH_FRAC: begin
            if (is_digit && count_ff != 2'd3) begin
            end else if (is_close) begin
               hit = 1'b1;
            end else begin
               miss = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // pad fraction on the right to milliseconds
      case (count_ff)
         2'd1:    frac_pad = 17'(frac_ff) * 17'd100;
         2'd2:    frac_pad = 17'(frac_ff) * 17'd10;
         default: frac_pad = 17'(frac_ff);
      endcase

      tag_in.is_tag  = hit;
      tag_in.minutes = min_ff;
      tag_in.seconds = sec_ff;
      tag_in.frac_ms = frac_pad[9:0];
   end

   // Next state
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      min_in   = min_ff;
      sec_in   = sec_ff;
      frac_in  = frac_ff;
      case (phase_ff)
         PH_MIN: begin
            if (is_digit && count_ff != 2'd3) begin
               min_in   = min_step[9:0];
               count_in = count_ff + 2'd1;
            end else if (is_colon && count_ff != 2'd0) begin
               phase_in = PH_SEC;
               count_in = 2'd0;
            end
         end
         PH_SEC: begin
            if (is_digit && count_ff < 2'd2) begin
               sec_in   = sec_step[6:0];
               count_in = count_ff + 2'd1;
            end else if (is_sep && count_ff != 2'd0) begin
               phase_in = PH_FRAC;
               count_in = 2'd0;
            end
         end
         PH_FRAC: begin
            if (is_digit && count_ff != 2'd3) begin
               frac_in  = frac_step[9:0];
               count_in = count_ff + 2'd1;
            end
         end
         default: begin
         end
      endcase

      if (hit) begin
         phase_in = PH_WAIT;
         count_in = 2'd0;
      end else if (miss || phase_ff == PH_WAIT) begin
         // a rejecting '[' opens the next candidate right away
         if (is_open) begin
            phase_in = PH_MIN;
            count_in = 2'd0;
            min_in   = 10'd0;
            sec_in   = 7'd0;
            frac_in  = 10'd0;
         end else begin
            phase_in = PH_WAIT;
            count_in = 2'd0;
         end
      end

      if (take) begin
         mid_valid_in = hit || miss;
      end else begin
         mid_valid_in = mid_valid_ff && !out_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WAIT;
         count_ff     <= 2'd0;
         min_ff       <= 10'd0;
         sec_ff       <= 7'd0;
         frac_ff      <= 10'd0;
         mid_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            phase_ff <= phase_in;
            count_ff <= count_in;
            min_ff   <= min_in;
            sec_ff   <= sec_in;
            frac_ff  <= frac_in;
         end
         mid_valid_ff <= mid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         tag_ff <= tag_in;
      end
   end

   assign mid_valid = mid_valid_ff;
   assign mid_tag   = tag_ff;

   `CHK_ALWAYS(a_stall_needs_word, clock, in_stall |-> mid_valid_ff, "stall without a held word")
   `CHK_PROP(a_wait_silent, clock, reset, take && phase_ff == PH_WAIT |=> !mid_valid_ff, "word from idle scan")
   `CHK_PROP(a_close_phase, clock, reset, take && hit |-> phase_ff == PH_SEC || phase_ff == PH_FRAC, "close outside sec/frac")
   `CHK_PROP(a_sec_digits, clock, reset, phase_ff == PH_SEC |-> count_ff != 2'd3, "too many second digits")

endmodule

FILE: hdl/lttp_calc.sv
// Result stage: scales the parsed tag to milliseconds into the output register.
// Depends on lttp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lttp_calc
   import lttp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              mid_valid,
   input  tag_type           mid_tag,
   output logic              mid_ready,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_is_time_tag,
   output logic [TIME_W-1:0] rsp_time_ms
);

   logic              rsp_valid_ff;
   logic              is_tag_ff;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [TIME_W-1:0] min_ms;
   logic [16:0]       sec_ms;

   assign mid_ready = !rsp_valid_ff || !rsp_stall;

   assign min_ms  = TIME_W'(mid_tag.minutes) * MS_PER_MIN;
   assign sec_ms  = 17'(mid_tag.seconds) * MS_PER_SEC;
   assign time_in = mid_tag.is_tag ? (min_ms + TIME_W'(sec_ms) + TIME_W'(mid_tag.frac_ms))
                                   : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (mid_ready) begin
         rsp_valid_ff <= mid_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_ready && mid_valid) begin
         is_tag_ff <= mid_tag.is_tag;
         time_ff   <= time_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_time_tag = is_tag_ff;
   assign rsp_time_ms     = time_ff;

   `CHK_PROP(a_reject_zero, clock, reset, rsp_valid_ff && !is_tag_ff |-> time_ff == '0, "reject word with time")
   `CHK_PROP(a_load_shows, clock, reset, mid_valid && mid_ready |=> rsp_valid_ff, "taken word not shown")
   `CHK_PROP(a_time_range, clock, reset, rsp_valid_ff |-> time_ff <= TIME_MAX, "time out of range")

endmodule
